FILE: rtl/core/rbf_svm_classifier_assert.svh
// Assertion macros for the rbf_svm_classifier checker
`ifndef RBF_SVM_CLASSIFIER_ASSERT_SVH
`define RBF_SVM_CLASSIFIER_ASSERT_SVH
`define RBF_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
`define RBF_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`endif

FILE: rtl/core/rbf_pkg.sv
// Shared constants, types and exponential tables of the RBF SVM classifier
`timescale 1ns / 1ps
package rbf_pkg;
  localparam int VECTOR_DEPTH = 1024;
  localparam int EXP_FRACTION_ENTRIES = 256;
  localparam int AW = $clog2(VECTOR_DEPTH);
  localparam int FW = $clog2(EXP_FRACTION_ENTRIES);
  localparam int CNTW = AW + 1;

  localparam logic [2:0] REG_INTERCEPT = 3'd0;
  localparam logic [2:0] REG_COUNT     = 3'd1;
  localparam logic [2:0] REG_MEAN_A    = 3'd2;
  localparam logic [2:0] REG_MEAN_B    = 3'd3;
  localparam logic [2:0] REG_MEAN_C    = 3'd4;
  localparam logic [2:0] REG_INV_A     = 3'd5;
  localparam logic [2:0] REG_INV_B     = 3'd6;
  localparam logic [2:0] REG_INV_C     = 3'd7;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  typedef struct packed {
    logic signed [31:0] intercept;
    logic [10:0] vector_count;
    logic signed [31:0] mean_a, mean_b, mean_c;
    logic [31:0] inv_a, inv_b, inv_c;
  } cfg_regs_t;

  function automatic logic [16:0] int_tab(input logic [3:0] k);
    logic [16:0] r;
    begin
      case (k)
        4'd0: r = 17'd65536; 4'd1: r = 17'd24109; 4'd2: r = 17'd8869;
        4'd3: r = 17'd3263;  4'd4: r = 17'd1200;  4'd5: r = 17'd442;
        4'd6: r = 17'd162;   4'd7: r = 17'd60;    4'd8: r = 17'd22;
        4'd9: r = 17'd8;     4'd10: r = 17'd3;    4'd11: r = 17'd1;
        default: r = 17'd0;
      endcase
      return r;
    end
  endfunction

  // Taylor series in Q32.32, evaluated at elaboration into a constant table
  function automatic logic [16:0] exp_neg_frac(input int j);
    logic [63:0] x, term;
    longint sum;
    begin
      x = (64'(j) << 32) / EXP_FRACTION_ENTRIES;
      term = 64'd1 << 32;
      sum = longint'(term);
      for (int k = 1; k <= 24; k++) begin
        term = 64'((128'(term) * 128'(x)) >> 32) / 64'(k);
        if (k % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      return 17'((64'(sum) + 64'd32768) >> 16);
    end
  endfunction

  typedef logic [16:0] ftab_t [EXP_FRACTION_ENTRIES];

  function automatic ftab_t build_ftab();
    ftab_t t;
    begin
      for (int j = 0; j < EXP_FRACTION_ENTRIES; j++) t[j] = exp_neg_frac(j);
      return t;
    end
  endfunction

  localparam ftab_t FTAB = build_ftab();
endpackage

FILE: rtl/core/rbf_stream_if.sv
// Valid/ready channel interfaces for items, results and configuration
`timescale 1ns / 1ps
interface rbf_in_if;
  logic valid, ready;
  logic operation;
  logic [9:0] entry_index;
  logic signed [31:0] coefficient, vector_a, vector_b, vector_c;
  logic signed [31:0] point_a, point_b, point_c;
  modport source(output valid, operation, entry_index, coefficient, vector_a, vector_b,
                 vector_c, point_a, point_b, point_c, input ready);
  modport sink(input valid, operation, entry_index, coefficient, vector_a, vector_b,
               vector_c, point_a, point_b, point_c, output ready);
endinterface

interface rbf_out_if;
  logic valid, ready;
  logic is_classification, inside_res;
  logic signed [31:0] score;
  modport source(output valid, is_classification, inside_res, score, input ready);
  modport sink(input valid, is_classification, inside_res, score, output ready);
endinterface

interface rbf_cfg_if;
  logic valid, ready;
  logic [2:0] index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/core/rbf_svm_classifier.sv
// Top level of the RBF-kernel SVM classifier
//
// Channels: in_ (request items), out_ (one result per request), cfg_ (register
// writes, index 0..7, always ready; write only while idle).
// A load request writes one support vector and its coefficient into the memory
// and is acknowledged in the next cycle with is_classification low.
// A classify request standardizes the point, then walks the first vector_count
// memory entries (vector_count capped at VECTOR_DEPTH), one per cycle through a
// single read port and the kernel pipeline; the result is registered once the
// states S_STD, S_STD2, S_WALK, S_DRAIN and S_OUT have passed.
// One classify request is worked on at a time, so a new request is taken only after
// its walk and drain are done; loads are taken one per cycle while out_ready is high.
// The output register holds a result until out_ready; a new request is taken
// only once that register is free or is being emptied.
// Synchronous active-low reset clears control state and the registers to their
// reset values; the memories are not cleared and must be loaded before use.
`timescale 1ns / 1ps
module rbf_svm_classifier (
  input logic clk,
  input logic rst_n,
  rbf_in_if.sink in_ch,
  rbf_out_if.source out_ch,
  rbf_cfg_if.sink cfg_ch
);
  import rbf_pkg::*;
  rbf_ctrl u_ctrl (.clk, .rst_n, .in_ch, .out_ch, .cfg_ch);
endmodule

FILE: rtl/core/rbf_store.sv
// Support vector and coefficient memory, one write port and one registered read port
`timescale 1ns / 1ps
module rbf_store (
  input  logic clk,
  input  logic wr_en,
  input  logic [rbf_pkg::AW-1:0] wr_addr,
  input  logic [127:0] wr_data,
  input  logic [rbf_pkg::AW-1:0] rd_addr,
  output logic [127:0] rd_data
);
  import rbf_pkg::*;
  logic [127:0] mem [VECTOR_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

FILE: rtl/core/rbf_kernel.sv
// Pipelined kernel evaluation: distance, exponential lookup and weighted term
`timescale 1ns / 1ps
module rbf_kernel (
  input  logic clk,
  input  logic rst_n,
  input  logic in_vld,
  input  logic signed [31:0] sa, sb, sc,
  input  logic [127:0] entry,
  output logic term_vld,
  output logic signed [48:0] term
);
  import rbf_pkg::*;
  // entry: {coef, vc, vb, va}
  logic signed [32:0] da, db, dc;
  logic s1_vld_r, s1_far_r;
  logic signed [19:0] da_r, db_r, dc_r;
  logic signed [31:0] coef1_r;
  logic [38:0] qa_r, qb_r, qc_r;
  logic s2_vld_r, s2_far_r;
  logic signed [31:0] coef2_r;
  logic [40:0] sum2;
  logic [24:0] sq_dist;
  logic [16:0] it, ft;
  logic [33:0] kprod_r;
  logic s3_vld_r;
  logic signed [31:0] coef3_r;
  logic [16:0] kr;
  logic [15:0] kv;
  logic signed [48:0] p_r;
  logic s4_vld_r;
  logic [48:0] mag;

  always_comb begin
    da = 33'(sa) - 33'(signed'(entry[31:0]));
    db = 33'(sb) - 33'(signed'(entry[63:32]));
    dc = 33'(sc) - 33'(signed'(entry[95:64]));
  end

  function automatic logic near(input logic signed [32:0] d);
    return (d < 33'sd262144) && (d > -33'sd262144);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0; s2_vld_r <= 1'b0; s3_vld_r <= 1'b0; s4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld; s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r; s4_vld_r <= s3_vld_r;
    end
    s1_far_r <= !(near(da) && near(db) && near(dc));
    da_r <= da[19:0]; db_r <= db[19:0]; dc_r <= dc[19:0];
    coef1_r <= entry[127:96];
    qa_r <= 39'(da_r * da_r); qb_r <= 39'(db_r * db_r); qc_r <= 39'(dc_r * dc_r);
    s2_far_r <= s1_far_r; coef2_r <= coef1_r;
    kprod_r <= (s2_far_r || sq_dist[24:20] != 5'd0) ? 34'd0 : 34'(it * ft);
    coef3_r <= coef2_r;
    p_r <= 49'(coef3_r * $signed({1'b0, kv}));
  end

  always_comb begin
    sum2 = 41'(qa_r) + 41'(qb_r) + 41'(qc_r);
    sq_dist = sum2[40:16];
    it = int_tab(sq_dist[19:16]);
    ft = FTAB[sq_dist[15:16-FW]];
    kr = 17'((35'(kprod_r) + 35'd32768) >> 16);
    kv = kr[16] ? 16'hFFFF : kr[15:0];
    mag = p_r[48] ? 49'(-p_r) : p_r;
  end

  // floor of p/2^16 on negative values via ceil of the magnitude
  assign term = p_r[48] ? -49'((mag + 49'd65535) >> 16) : 49'(p_r >>> 16);
  assign term_vld = s4_vld_r;
endmodule

FILE: rtl/core/rbf_ctrl.sv
// Sequencer: config registers, standardization, memory walk and accumulation
`timescale 1ns / 1ps
module rbf_ctrl (
  input  logic clk,
  input  logic rst_n,
  rbf_in_if.sink in_ch,
  rbf_out_if.source out_ch,
  rbf_cfg_if.sink cfg_ch
);
  import rbf_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_STD, S_STD2, S_WALK, S_DRAIN, S_OUT} state_t;
  state_t st_r, st_nxt;
  cfg_regs_t cfg_r;
  logic [31:0] pa_r, pb_r, pc_r;
  logic signed [32:0] dfa_r, dfb_r, dfc_r;
  logic [64:0] ma_r, mb_r, mc_r;
  logic na_r, nb_r, nc_r;
  logic signed [31:0] sa_r, sb_r, sc_r;
  logic [CNTW-1:0] n_r, rd_cnt_r, done_cnt_r;
  logic signed [49:0] acc_r;
  logic rd_vld_r;
  logic out_vld_r, out_cls_r, out_ins_r;
  logic signed [31:0] out_val_r;
  logic [127:0] rd_data;
  logic term_vld;
  logic signed [48:0] term;
  logic wr_en;
  logic [CNTW-1:0] n_lim;

  rbf_store u_store (
    .clk, .wr_en, .wr_addr(in_ch.entry_index[AW-1:0]),
    .wr_data({in_ch.coefficient, in_ch.vector_c, in_ch.vector_b, in_ch.vector_a}),
    .rd_addr(rd_cnt_r[AW-1:0]), .rd_data);

  rbf_kernel u_kernel (
    .clk, .rst_n, .in_vld(rd_vld_r), .sa(sa_r), .sb(sb_r), .sc(sc_r),
    .entry(rd_data), .term_vld, .term);

  assign in_ch.ready = (st_r == S_IDLE) && (!out_vld_r || out_ch.ready);
  assign cfg_ch.ready = 1'b1;
  assign wr_en = in_ch.valid && in_ch.ready && in_ch.operation == OP_LOAD;
  assign n_lim = (cfg_r.vector_count > 11'(VECTOR_DEPTH)) ? CNTW'(VECTOR_DEPTH)
                                                             : CNTW'(cfg_r.vector_count);
  assign out_ch.valid = out_vld_r;
  assign out_ch.is_classification = out_cls_r;
  assign out_ch.inside_res = out_ins_r;
  assign out_ch.score = out_val_r;

  function automatic logic signed [31:0] std_fin(input logic neg, input logic [64:0] m);
    logic [48:0] q;
    begin
      q = m[64:16];
      if (q > 49'h7FFFFFFF) return neg ? 32'sh80000000 : 32'sh7FFFFFFF;
      return neg ? -32'(q) : 32'(q);
    end
  endfunction

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:  if (in_ch.valid && in_ch.ready && in_ch.operation == OP_CLASSIFY) st_nxt = S_STD;
      S_STD:   st_nxt = S_STD2;
      S_STD2:  st_nxt = S_WALK;
      S_WALK:  if (rd_cnt_r >= n_r) st_nxt = S_DRAIN;
      S_DRAIN: if (done_cnt_r == n_r) st_nxt = S_OUT;
      S_OUT:   st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_vld_r <= 1'b0;
      rd_vld_r <= 1'b0;
      cfg_r <= '{intercept: '0, vector_count: '0, mean_a: '0, mean_b: '0, mean_c: '0,
                 inv_a: 32'd65536, inv_b: 32'd65536, inv_c: 32'd65536};
    end else begin
      st_r <= st_nxt;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_INTERCEPT: cfg_r.intercept <= cfg_ch.data;
          REG_COUNT:     cfg_r.vector_count <= cfg_ch.data[10:0];
          REG_MEAN_A:    cfg_r.mean_a <= cfg_ch.data;
          REG_MEAN_B:    cfg_r.mean_b <= cfg_ch.data;
          REG_MEAN_C:    cfg_r.mean_c <= cfg_ch.data;
          REG_INV_A:     cfg_r.inv_a <= cfg_ch.data;
          REG_INV_B:     cfg_r.inv_b <= cfg_ch.data;
          REG_INV_C:     cfg_r.inv_c <= cfg_ch.data;
          default: ;
        endcase
      end
      rd_vld_r <= (st_r == S_WALK) && (rd_cnt_r < n_r);
      if (in_ch.valid && in_ch.ready && in_ch.operation == OP_LOAD) begin
        out_vld_r <= 1'b1; out_cls_r <= 1'b0; out_ins_r <= 1'b0; out_val_r <= '0;
      end else if (st_r == S_OUT) begin
        out_vld_r <= 1'b1; out_cls_r <= 1'b1; out_ins_r <= !acc_r[49];
        if (acc_r > 50'sh7FFFFFFF) out_val_r <= 32'sh7FFFFFFF;
        else if (acc_r < -50'sh80000000) out_val_r <= 32'sh80000000;
        else out_val_r <= acc_r[31:0];
      end else if (out_vld_r && out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
    if (in_ch.valid && in_ch.ready) begin
      pa_r <= in_ch.point_a; pb_r <= in_ch.point_b; pc_r <= in_ch.point_c;
      n_r <= n_lim;
      acc_r <= 50'(cfg_r.intercept);
      rd_cnt_r <= '0; done_cnt_r <= '0;
    end
    if (st_r == S_STD) begin
      dfa_r <= 33'(signed'(pa_r)) - 33'(cfg_r.mean_a);
      dfb_r <= 33'(signed'(pb_r)) - 33'(cfg_r.mean_b);
      dfc_r <= 33'(signed'(pc_r)) - 33'(cfg_r.mean_c);
    end
    // |p - mean| never exceeds 2^32 - 1, so a 32 x 32 product covers it
    na_r <= dfa_r[32]; nb_r <= dfb_r[32]; nc_r <= dfc_r[32];
    ma_r <= 65'(32'(dfa_r[32] ? -dfa_r : dfa_r) * cfg_r.inv_a);
    mb_r <= 65'(32'(dfb_r[32] ? -dfb_r : dfb_r) * cfg_r.inv_b);
    mc_r <= 65'(32'(dfc_r[32] ? -dfc_r : dfc_r) * cfg_r.inv_c);
    if (st_r == S_WALK) begin
      if (st_nxt == S_WALK && rd_cnt_r == '0) begin
        sa_r <= std_fin(na_r, ma_r); sb_r <= std_fin(nb_r, mb_r);
        sc_r <= std_fin(nc_r, mc_r);
      end
      if (rd_cnt_r < n_r) rd_cnt_r <= rd_cnt_r + 1'b1;
    end
    if (term_vld) begin
      acc_r <= acc_r + 50'(term);
      done_cnt_r <= done_cnt_r + 1'b1;
    end
  end
endmodule

FILE: rtl/core/rbf_svm_classifier_checker.sv
// Port-level checker for the RBF SVM classifier, bound to the top level
`timescale 1ns / 1ps
`include "rbf_svm_classifier_assert.svh"
module rbf_svm_classifier_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid, in_ready, in_operation,
  input logic out_valid, out_ready, out_is_classification, out_inside_res,
  input logic [31:0] out_score
);
  `RBF_ASSERT_NEXT(a_load_ack, clk, rst_n, in_valid && in_ready && !in_operation,
                   out_valid && !out_is_classification)
  `RBF_ASSERT_IMPL(a_ack_zero, clk, rst_n, out_valid && !out_is_classification,
                   !out_inside_res && out_score == 32'd0)
  `RBF_ASSERT_IMPL(a_sign, clk, rst_n, out_valid && out_is_classification,
                   out_inside_res == !out_score[31])
  `RBF_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && in_ready && in_operation, !in_ready)
endmodule

bind rbf_svm_classifier rbf_svm_classifier_checker u_checker (
  .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .in_operation(in_ch.operation), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_is_classification(out_ch.is_classification), .out_inside_res(out_ch.inside_res),
  .out_score(out_ch.score));

FILE: tb/rbf_svm_classifier_test.sv
// Self-checking testbench for the RBF SVM classifier: loads, classifies, register sweeps
`timescale 1ns / 1ps
module rbf_svm_classifier_test;
  import rbf_pkg::*;

  typedef struct packed {
    logic operation;
    logic [9:0] entry_index;
    logic signed [31:0] coefficient, vector_a, vector_b, vector_c;
    logic signed [31:0] point_a, point_b, point_c;
  } svm_req_t;

  typedef struct packed {
    logic is_classification;
    logic inside_res;
    logic signed [31:0] score;
  } svm_res_t;

  localparam int WATCHDOG_LIMIT = 40000;

  logic clk, rst_n;
  rbf_in_if in_ch();
  rbf_out_if out_ch();
  rbf_cfg_if cfg_ch();

  rbf_svm_classifier u_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink),
                            .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink));

  // predictor state
  logic signed [31:0] sv_a_mem [VECTOR_DEPTH];
  logic signed [31:0] sv_b_mem [VECTOR_DEPTH];
  logic signed [31:0] sv_c_mem [VECTOR_DEPTH];
  logic signed [31:0] coef_mem [VECTOR_DEPTH];
  logic [31:0] exp_frac [EXP_FRACTION_ENTRIES];
  logic [31:0] exp_int [16] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60,
                                22, 8, 3, 1, 0, 0, 0, 0};
  logic [31:0] regs [8];

  svm_req_t pending_reqs[$];
  svm_res_t expected_results[$];
  int errors = 0;
  int send_idle_pct = 29, recv_idle_pct = 81;
  bit hold_sender = 0;
  bit in_taken = 0;
  int idle_cycles = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] taylor_exp_frac(int j);
    logic [63:0] x, term;
    longint sum;
    begin
      x = (64'(j) << 32) / EXP_FRACTION_ENTRIES;
      term = 64'd1 << 32;
      sum = longint'(term);
      for (int k = 1; k <= 24; k++) begin
        term = 64'((128'(term) * 128'(x)) >> 32) / 64'(k);
        if (k % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      return 32'((64'(sum) + 64'd32768) >> 16);
    end
  endfunction

  function automatic longint sat_s32(longint v);
    if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
    if (v < -64'sh80000000) return -64'sh80000000;
    return v;
  endfunction

  function automatic longint standardized(logic signed [31:0] p, logic signed [31:0] m,
                                          logic [31:0] inv);
    longint diff, q;
    logic [63:0] mag;
    begin
      diff = longint'(p) - longint'(m);
      mag = diff < 0 ? 64'(-diff) : 64'(diff);
      q = longint'((128'(mag) * 128'(inv)) >> 16);
      return sat_s32(diff < 0 ? -q : q);
    end
  endfunction

  function automatic longint rbf_weight(longint da, longint db, longint dc);
    longint lim, sq_dist, v;
    begin
      lim = 64'sd1 << 18;
      if (da >= lim || da <= -lim || db >= lim || db <= -lim || dc >= lim || dc <= -lim)
        return 0;
      sq_dist = (da * da + db * db + dc * dc) >>> 16;
      if (sq_dist >= (64'sd16 << 16)) return 0;
      v = (longint'(exp_int[sq_dist >>> 16]) *
           longint'(exp_frac[((sq_dist & 16'hFFFF) * EXP_FRACTION_ENTRIES) >>> 16]) +
           32768) >>> 16;
      return v > 65535 ? 65535 : v;
    end
  endfunction

  function automatic svm_res_t predict_result(svm_req_t r);
    svm_res_t res;
    longint acc, sa, sb, sc, p;
    int n;
    begin
      res = '0;
      if (r.operation == OP_LOAD) begin
        sv_a_mem[r.entry_index] = r.vector_a;
        sv_b_mem[r.entry_index] = r.vector_b;
        sv_c_mem[r.entry_index] = r.vector_c;
        coef_mem[r.entry_index] = r.coefficient;
        return res;
      end
      sa = standardized(r.point_a, regs[REG_MEAN_A], regs[REG_INV_A]);
      sb = standardized(r.point_b, regs[REG_MEAN_B], regs[REG_INV_B]);
      sc = standardized(r.point_c, regs[REG_MEAN_C], regs[REG_INV_C]);
      n = regs[REG_COUNT] > VECTOR_DEPTH ? VECTOR_DEPTH : int'(regs[REG_COUNT]);
      acc = longint'($signed(regs[REG_INTERCEPT]));
      for (int i = 0; i < n; i++) begin
        p = longint'(coef_mem[i]) * rbf_weight(sa - sv_a_mem[i], sb - sv_b_mem[i],
                                                 sc - sv_c_mem[i]);
        if (p < 0) acc -= (-p + 65535) >>> 16;
        else acc += p >>> 16;
      end
      res.is_classification = 1;
      res.inside_res = acc >= 0;
      res.score = 32'(sat_s32(acc));
      return res;
    end
  endfunction

  // driver: a request leaves the queue once the monitor saw it taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 0;
    end else if (!in_ch.valid || in_taken) begin
      if (in_taken) void'(pending_reqs.pop_front());
      if (!(hold_sender && expected_results.size() != 0) && pending_reqs.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1;
        {in_ch.operation, in_ch.entry_index, in_ch.coefficient, in_ch.vector_a,
         in_ch.vector_b, in_ch.vector_c, in_ch.point_a, in_ch.point_b, in_ch.point_c}
          <= pending_reqs[0];
      end else begin
        in_ch.valid <= 0;
      end
    end
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor
  always @(posedge clk) begin
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(predict_result(pending_reqs[0]));
      if (out_ch.valid && out_ch.ready) begin
        svm_res_t want;
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result: actual %0b %0b %0d", $time,
                   out_ch.is_classification, out_ch.inside_res, out_ch.score);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (want.is_classification !== out_ch.is_classification ||
              want.inside_res !== out_ch.inside_res ||
              want.score !== out_ch.score) begin
            $display("%0t mismatch: expected %0b %0b %0d actual %0b %0b %0d", $time,
                     want.is_classification, want.inside_res, want.score,
                     out_ch.is_classification, out_ch.inside_res, out_ch.score);
            errors++;
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    regs[idx] = idx == REG_COUNT ? (value & 32'h7FF) : value;
    @(negedge clk);
    cfg_ch.valid <= 0;
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [31:0] near_val();
    case ($urandom_range(3))
      0: return $signed($urandom_range(0, 32'h60000)) - 32'sh30000;
      1: return $urandom;
      default: return $signed($urandom_range(0, 32'h28000)) - 32'sh14000;
    endcase
  endfunction

  task automatic add_load(int idx);
    svm_req_t r;
    r = '0;
    {r.point_a, r.point_b, r.point_c} = {$urandom, $urandom, $urandom};
    r.operation = OP_LOAD;
    r.entry_index = 10'(idx);
    r.coefficient = $urandom_range(3) == 0 ? $urandom : near_val() * 4;
    r.vector_a = near_val();
    r.vector_b = near_val();
    r.vector_c = near_val();
    pending_reqs.push_back(r);
  endtask

  task automatic add_classify(logic signed [31:0] a, logic signed [31:0] b,
                              logic signed [31:0] c);
    svm_req_t r;
    r = '0;
    {r.entry_index, r.coefficient, r.vector_a, r.vector_b, r.vector_c}
      = {10'($urandom), $urandom, $urandom, $urandom, $urandom};
    r.operation = OP_CLASSIFY;
    r.point_a = a;
    r.point_b = b;
    r.point_c = c;
    pending_reqs.push_back(r);
  endtask

  task automatic random_phase(int items, int max_count);
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(3) == 0) add_load($urandom_range(max_count - 1));
      else add_classify(near_val(), near_val(), near_val());
    end
  endtask

  initial begin
    in_ch.valid = 0;
    in_ch.operation = 0; in_ch.entry_index = 0; in_ch.coefficient = 0;
    in_ch.vector_a = 0; in_ch.vector_b = 0; in_ch.vector_c = 0;
    in_ch.point_a = 0; in_ch.point_b = 0; in_ch.point_c = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0; cfg_ch.index = REG_INTERCEPT; cfg_ch.data = 0;
    for (int j = 0; j < EXP_FRACTION_ENTRIES; j++) exp_frac[j] = taylor_exp_frac(j);
    regs = '{0, 0, 0, 0, 0, 65536, 65536, 65536};
    rst_n = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;

    // directed: zero count, then loads of extremes and matching points
    add_classify(32'sh7FFFFFFF, 32'sh80000000, 0);
    add_load(0);
    add_load(1);
    pending_reqs[$].coefficient = 32'sh80000000;
    add_load(2);
    pending_reqs[$].coefficient = 32'sh7FFFFFFF;
    pending_reqs[$].vector_a = 0; pending_reqs[$].vector_b = 0; pending_reqs[$].vector_c = 0;
    add_load(3);
    pending_reqs[$].vector_a = 32'sh7FFFFFFF; pending_reqs[$].vector_b = 32'sh80000000;
    add_load(1023);
    drain();
    write_reg(REG_COUNT, 32'd4);
    write_reg(REG_INTERCEPT, 32'sh80000000);
    add_classify(0, 0, 0);
    add_classify(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    add_classify(32'sh80000000, 32'sh80000000, 32'sh80000000);
    add_classify(32'sh8000, -32'sh8000, 32'sh10000);
    drain();
    write_reg(REG_INTERCEPT, 32'sh7FFFFFFF);
    write_reg(REG_MEAN_A, 32'sh80000000);
    write_reg(REG_INV_A, 32'hFFFFFFFF);
    write_reg(REG_INV_B, 0);
    add_classify(32'sh7FFFFFFF, 5, 0);
    add_classify(0, 0, 0);
    drain();

    // fill a block of slots, then walks over all of them
    for (int i = 0; i < 32; i++) add_load(i);
    drain();
    write_reg(REG_COUNT, 32'd32);
    write_reg(REG_INTERCEPT, 0);
    add_classify($urandom, $urandom, $urandom);
    add_classify(near_val(), near_val(), near_val());
    drain();

    regs_phase: begin
      write_reg(REG_MEAN_A, 32'h8000);
      write_reg(REG_MEAN_B, -32'sh4000);
      write_reg(REG_MEAN_C, 32'h7FFFFFFF);
      write_reg(REG_INV_A, 32'h10000);
      write_reg(REG_INV_B, 32'h18000);
      write_reg(REG_INV_C, 32'h0);
      write_reg(REG_COUNT, 32'd8);
      write_reg(REG_INTERCEPT, -32'sh20000);
    end
    random_phase(175, 8);
    drain();

    send_idle_pct = 81; recv_idle_pct = 29;
    write_reg(REG_MEAN_C, 0);
    write_reg(REG_INV_C, 32'h10000);
    write_reg(REG_COUNT, 32'd16);
    write_reg(REG_INTERCEPT, 32'sh10000);
    random_phase(175, 16);
    drain();

    // sender waits for every outstanding result before each request
    hold_sender = 1;
    add_load(5);
    add_classify(0, 0, 0);
    add_classify(near_val(), near_val(), near_val());
    drain();
    hold_sender = 0;

    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(REG_COUNT, 32'd3);
    write_reg(REG_MEAN_A, 0);
    write_reg(REG_MEAN_B, 0);
    write_reg(REG_INV_A, 32'h8000);
    write_reg(REG_INV_B, 32'h10000);
    random_phase(175, 3);
    drain();

    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
